@@ rtl/core/rcs_pkg.sv @@
`timescale 1ns / 1ps

package rcs_pkg;

    // Default width of the stored toggle times.
    localparam int TimeBitsDefault = 32;

    localparam int TimeFieldW = 32;
    localparam int PosW       = 16;
    localparam int DpsW       = 8;
    localparam int PeriodW    = 16;
    localparam int ScaledW    = PosW + DpsW;
    localparam int DegW       = 18;
    localparam int RemW       = 7;
    localparam int CfgIdxW    = 8;
    localparam int CfgDataW   = 16;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_CRUISE_PERIOD = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_SECOND_PERIOD = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_THIRD_PERIOD  = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_DEG_PER_STEP  = 8'd3;

    localparam logic [PeriodW-1:0] CRUISE_PERIOD_RST = 16'd1000;
    localparam logic [PeriodW-1:0] SECOND_PERIOD_RST = 16'd380;
    localparam logic [PeriodW-1:0] THIRD_PERIOD_RST  = 16'd520;
    localparam logic [DpsW-1:0]    DEG_PER_STEP_RST  = 8'd90;

    // Slow start: scaled position limits and the half-step periods below them.
    localparam logic [ScaledW-1:0] SLOW_LIMIT_1  = 24'd1000;
    localparam logic [ScaledW-1:0] SLOW_LIMIT_2  = 24'd1500;
    localparam logic [ScaledW-1:0] SLOW_LIMIT_3  = 24'd2000;
    localparam logic [PeriodW-1:0] SLOW_PERIOD_1 = 16'd3000;
    localparam logic [PeriodW-1:0] SLOW_PERIOD_2 = 16'd2000;
    localparam logic [PeriodW-1:0] SLOW_PERIOD_3 = 16'd1400;

    localparam logic [PosW-1:0] POS_MAX = 16'hFFFF;

    // Angles in whole degrees.
    localparam logic [DegW-1:0] DEG_EJECT_CHECK = 18'd345;
    localparam logic [DegW-1:0] DEG_RAM_ON      = 18'd165;
    localparam logic [DegW-1:0] DEG_AIR_ON      = 18'd280;
    localparam logic [DegW-1:0] DEG_AIR_OFF     = 18'd330;
    localparam logic [DegW-1:0] DEG_SECOND_TURN = 18'd185;
    localparam logic [DegW-1:0] DEG_THIRD_TURN  = 18'd186;
    localparam logic [DegW-1:0] DEG_THIRD_START = 18'd45;

    // floor(x / 100) = (x * DIV_RECIP) >> DIV_SHIFT for every x below 2^24.
    localparam int               RecipW    = 25;
    localparam logic [RecipW-1:0] DIV_RECIP = 25'd21474837;
    localparam int               DIV_SHIFT = 31;

    typedef struct packed {
        logic [TimeFieldW-1:0] time_us;
        logic                  start_ok;
        logic                  stop_button;
        logic                  home_sensor;
        logic                  exit_sensor;
        logic                  pipet_present;
        logic                  cap_present;
        logic                  overrun_present;
        logic                  second_home;
        logic                  second_away;
        logic                  third_home;
        logic                  third_away;
    } t_in_item;

    typedef struct packed {
        logic main_step;
        logic second_step;
        logic third_step;
        logic ram_on;
        logic air_on;
        logic count_pulse;
        logic running;
        logic ramping;
        logic eject_fault;
        logic feed_empty;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0]  reg_index;
        logic [CfgDataW-1:0] wdata;
    } t_cfg_write;

    typedef struct packed {
        logic [DegW-1:0] deg;
        logic [RemW-1:0] rem;
    } t_angle;

    // Adds one step's worth of hundredths of a degree to a quotient/remainder pair.
    function automatic t_angle add_step(input logic [DegW-1:0] deg,
                                        input logic [RemW-1:0] rem,
                                        input logic [DpsW-1:0] dps);
        logic [9:0] sum;
        t_angle     res;
        sum = {3'b000, rem} + {2'b00, dps};
        if (sum >= 10'd300) begin
            res.deg = deg + DegW'(3);
            res.rem = RemW'(sum - 10'd300);
        end else if (sum >= 10'd200) begin
            res.deg = deg + DegW'(2);
            res.rem = RemW'(sum - 10'd200);
        end else if (sum >= 10'd100) begin
            res.deg = deg + DegW'(1);
            res.rem = RemW'(sum - 10'd100);
        end else begin
            res.deg = deg;
            res.rem = RemW'(sum);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/rcs_stream_if.sv @@
`timescale 1ns / 1ps

interface rcs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rotary_cycle_sequencer_core.sv @@
`timescale 1ns / 1ps

// Rotary cycle sequencer. Each input item is one sensor sample tick with a microsecond
// timestamp; each tick yields exactly one result item with the step pin, actuator and status
// levels after that tick. Ticks are taken into an input register, evaluated combinationally and
// held in a result register, so one tick per clock is sustained while the result side is
// ready and no recomputation runs. The main axis angle is kept incrementally as a scaled
// position plus whole degrees and a remainder; a write to the degrees-per-step register
// therefore starts a recomputation in three steps (multiply, divide by reciprocal, remainder)
// during which neither ticks nor further configuration writes are taken.
module rotary_cycle_sequencer_core #(
    parameter int TIME_BITS = rcs_pkg::TimeBitsDefault
) (
    input logic           i_clk,
    input logic           i_rst_n,
    rcs_stream_if.sink    i_cfg,
    rcs_stream_if.sink    i_in,
    rcs_stream_if.source  o_out
);
    import rcs_pkg::*;

    localparam logic [1:0] CALC_IDLE = 2'd0;
    localparam logic [1:0] CALC_MUL  = 2'd1;
    localparam logic [1:0] CALC_DIV  = 2'd2;
    localparam logic [1:0] CALC_REM  = 2'd3;

    localparam int ProdW = ScaledW + RecipW;

    // Configuration.
    logic [PeriodW-1:0] r_cruise_period;
    logic [PeriodW-1:0] r_second_period;
    logic [PeriodW-1:0] r_third_period;
    logic [DpsW-1:0]    r_dps;
    logic [1:0]         r_calc_state;

    // Handshake stages.
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       w_advance;
    logic       w_fire;
    logic       w_cfg_fire;

    // Machine state and next values.
    logic                 r_run, n_run;
    logic                 r_slow, n_slow;
    logic                 r_stop, n_stop;
    logic                 r_fault, n_fault;
    logic                 r_eject_seen, n_eject_seen;
    logic                 r_pipets_out, n_pipets_out;
    logic                 r_caps_out, n_caps_out;
    logic                 r_count, n_count;
    logic [PosW-1:0]      r_pos, n_pos;
    logic [ScaledW-1:0]   r_scaled, n_scaled;
    logic [DegW-1:0]      r_deg, n_deg;
    logic [RemW-1:0]      r_rem, n_rem;
    logic [2:0]           r_phase, n_phase;
    logic [TIME_BITS-1:0] r_last [3];
    logic [TIME_BITS-1:0] n_last [3];
    logic [1:0]           r_act, n_act;
    logic [1:0]           r_axis_home, n_axis_home;

    // Tick evaluation temporaries.
    logic [TIME_BITS-1:0] w_now;
    logic [PeriodW-1:0]   w_period;
    logic                 w_running;
    logic                 w_overrun_empty;
    t_angle               w_step_angle;

    // Angle recomputation.
    logic [ProdW-1:0]     w_recip_prod;
    logic [ScaledW-1:0]   w_hundreds;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_advance;
    assign i_in.ready = (r_calc_state == CALC_IDLE) && (!r_in_valid || w_advance);
    assign i_cfg.ready = (r_calc_state == CALC_IDLE);
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_recip_prod = {{RecipW{1'b0}}, r_scaled} * {{ScaledW{1'b0}}, DIV_RECIP};
    assign w_hundreds   = {{(ScaledW-DegW){1'b0}}, r_deg} * ScaledW'(100);

    always_comb begin
        n_run        = r_run;
        n_slow       = r_slow;
        n_stop       = r_stop;
        n_fault      = r_fault;
        n_eject_seen = r_eject_seen;
        n_pipets_out = r_pipets_out;
        n_caps_out   = r_caps_out;
        n_count      = r_count;
        n_pos        = r_pos;
        n_scaled     = r_scaled;
        n_deg        = r_deg;
        n_rem        = r_rem;
        n_phase      = r_phase;
        n_last       = r_last;
        n_act        = r_act;
        n_axis_home  = r_axis_home;
        w_now           = TIME_BITS'(r_in.time_us);
        w_overrun_empty = !r_in.overrun_present;
        w_period        = r_cruise_period;
        w_step_angle    = '0;
        w_running       = 1'b0;

        if (r_in.start_ok) begin
            if (r_in.pipet_present) n_pipets_out = 1'b0;
            if (r_in.cap_present) n_caps_out = 1'b0;
            if (r_in.second_home && r_in.third_home && r_in.pipet_present
                    && r_in.cap_present) begin
                if (!n_run) n_fault = 1'b0;
                n_run  = 1'b1;
                n_stop = 1'b0;
            end
        end

        // The rest of the tick runs on the run state seen here, even if it ends at home.
        w_running = n_run;
        if (w_running) begin
            if (r_in.stop_button || n_fault || w_overrun_empty || n_pipets_out || n_caps_out)
                n_stop = 1'b1;
            n_count = r_in.exit_sensor;
            if (r_in.exit_sensor) n_eject_seen = 1'b1;
            if (r_deg == DEG_EJECT_CHECK && !n_eject_seen) n_fault = 1'b1;

            if (r_in.home_sensor && !n_slow) begin
                n_pipets_out = !r_in.pipet_present;
                n_caps_out   = !r_in.cap_present;
                n_pos        = '0;
                n_scaled     = '0;
                n_deg        = '0;
                n_rem        = '0;
                n_eject_seen = 1'b0;
                if (n_stop) begin
                    n_slow   = 1'b1;
                    n_run    = 1'b0;
                    n_act[0] = 1'b0;
                end
            end

            if (n_slow && n_scaled < SLOW_LIMIT_1) begin
                w_period = SLOW_PERIOD_1;
            end else if (n_slow && n_scaled < SLOW_LIMIT_2) begin
                w_period = SLOW_PERIOD_2;
            end else if (n_slow && n_scaled < SLOW_LIMIT_3) begin
                w_period = SLOW_PERIOD_3;
            end else begin
                n_slow   = 1'b0;
                w_period = r_cruise_period;
            end

            // Main axis: a rising step edge advances the position.
            if ((w_now - r_last[0]) > TIME_BITS'(w_period)) begin
                n_phase[0] = !r_phase[0];
                n_last[0]  = w_now;
                if (n_phase[0] && n_pos < POS_MAX) begin
                    w_step_angle = add_step(n_deg, n_rem, r_dps);
                    n_pos        = n_pos + PosW'(1);
                    n_scaled     = n_scaled + ScaledW'(r_dps);
                    n_deg        = w_step_angle.deg;
                    n_rem        = w_step_angle.rem;
                end
            end

            if (!n_slow) begin
                if (r_in.second_home) n_axis_home[0] = 1'b1;
                if (r_in.second_away) n_axis_home[0] = 1'b0;
                if (n_deg == DEG_RAM_ON && !w_overrun_empty) n_act[0] = 1'b1;
                if (n_deg == DEG_AIR_ON) begin
                    n_act[0] = 1'b0;
                    n_act[1] = 1'b1;
                end
                if (n_deg == DEG_AIR_OFF) n_act[1] = 1'b0;
                if ((n_deg < DEG_SECOND_TURN && n_axis_home[0])
                        || (n_deg > DEG_SECOND_TURN && !n_axis_home[0])) begin
                    if ((w_now - r_last[1]) > TIME_BITS'(r_second_period)) begin
                        n_phase[1] = !r_phase[1];
                        n_last[1]  = w_now;
                    end
                end
                if (r_in.third_home) n_axis_home[1] = 1'b1;
                if (r_in.third_away) n_axis_home[1] = 1'b0;
                if ((n_deg > DEG_THIRD_START && n_deg < DEG_THIRD_TURN && n_axis_home[1])
                        || (n_deg > DEG_THIRD_TURN && !n_axis_home[1])) begin
                    if ((w_now - r_last[2]) > TIME_BITS'(r_third_period)) begin
                        n_phase[2] = !r_phase[2];
                        n_last[2]  = w_now;
                    end
                end
            end
        end

        n_out.main_step   = n_phase[0];
        n_out.second_step = n_phase[1];
        n_out.third_step  = n_phase[2];
        n_out.ram_on      = n_act[0];
        n_out.air_on      = n_act[1];
        n_out.count_pulse = n_count;
        n_out.running     = n_run;
        n_out.ramping     = n_slow;
        n_out.eject_fault = n_fault;
        n_out.feed_empty  = n_pipets_out || n_caps_out || w_overrun_empty;
    end

    // Handshake stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in <= i_in.data;
        if (w_fire) r_out <= n_out;
    end

    // Configuration registers and the angle recomputation sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise_period <= CRUISE_PERIOD_RST;
            r_second_period <= SECOND_PERIOD_RST;
            r_third_period  <= THIRD_PERIOD_RST;
            r_dps           <= DEG_PER_STEP_RST;
            r_calc_state    <= CALC_IDLE;
        end else begin
            if (w_cfg_fire) begin
                unique case (i_cfg.data.reg_index)
                    REG_CRUISE_PERIOD: r_cruise_period <= i_cfg.data.wdata;
                    REG_SECOND_PERIOD: r_second_period <= i_cfg.data.wdata;
                    REG_THIRD_PERIOD:  r_third_period  <= i_cfg.data.wdata;
                    REG_DEG_PER_STEP: begin
                        r_dps        <= i_cfg.data.wdata[DpsW-1:0];
                        r_calc_state <= CALC_MUL;
                    end
                    default: ;
                endcase
            end else begin
                unique case (r_calc_state)
                    CALC_MUL: r_calc_state <= CALC_DIV;
                    CALC_DIV: r_calc_state <= CALC_REM;
                    CALC_REM: r_calc_state <= CALC_IDLE;
                    default:  r_calc_state <= CALC_IDLE;
                endcase
            end
        end
    end

    // Machine state: updated by a tick, or rebuilt from the position after a scale change.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_slow       <= 1'b1;
            r_stop       <= 1'b0;
            r_fault      <= 1'b0;
            r_eject_seen <= 1'b0;
            r_pipets_out <= 1'b0;
            r_caps_out   <= 1'b0;
            r_count      <= 1'b0;
            r_pos        <= '0;
            r_scaled     <= '0;
            r_deg        <= '0;
            r_rem        <= '0;
            r_phase      <= '0;
            r_last       <= '{default: '0};
            r_act        <= 2'b00;
            r_axis_home  <= 2'b11;
        end else if (w_fire) begin
            r_run        <= n_run;
            r_slow       <= n_slow;
            r_stop       <= n_stop;
            r_fault      <= n_fault;
            r_eject_seen <= n_eject_seen;
            r_pipets_out <= n_pipets_out;
            r_caps_out   <= n_caps_out;
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_scaled     <= n_scaled;
            r_deg        <= n_deg;
            r_rem        <= n_rem;
            r_phase      <= n_phase;
            r_last       <= n_last;
            r_act        <= n_act;
            r_axis_home  <= n_axis_home;
        end else begin
            unique case (r_calc_state)
                CALC_MUL: r_scaled <= {{DpsW{1'b0}}, r_pos} * {{PosW{1'b0}}, r_dps};
                CALC_DIV: r_deg    <= w_recip_prod[DIV_SHIFT +: DegW];
                CALC_REM: r_rem    <= RemW'(r_scaled - w_hundreds);
                default: ;
            endcase
        end
    end

endmodule

@@ test/rcs_level_checker.sv @@
`timescale 1ns / 1ps

module rcs_level_checker
    import rcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  t_cfg_write i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);

    localparam int ReportLimit = 10;

    // Bit i of a result item is named by entry i.
    string level_names [10] = '{"feed_empty", "eject_fault", "ramping", "running",
                                "count_pulse", "air_on", "ram_on", "third_step",
                                "second_step", "main_step"};

    logic [PeriodW-1:0] cruise_p, second_p, third_p;
    logic [DpsW-1:0]    dps;

    logic              run, slow, stop_l, fault, ej_seen, pip_out, cap_out;
    logic [PosW-1:0]   pos;
    logic [2:0]        phase;
    logic [31:0]       last_t [3];
    logic              ram, air, home2, home3, cnt_lvl;

    t_out_item levels_due [$];
    int        errors;
    int        reported;
    int        results;

    function automatic logic [ScaledW-1:0] scaled_pos();
        return ScaledW'(pos) * ScaledW'(dps);
    endfunction

    function automatic logic [ScaledW-1:0] angle_deg();
        return scaled_pos() / ScaledW'(100);
    endfunction

    // Toggles a step pin once its period has run out; true on a rising pin.
    function automatic logic toggle_axis(input int axis, input logic [31:0] now,
                                         input logic [PeriodW-1:0] period);
        logic [31:0] dt;
        dt = now - last_t[axis];
        toggle_axis = 1'b0;
        if (dt > 32'(period)) begin
            phase[axis] = ~phase[axis];
            toggle_axis = phase[axis];
            last_t[axis] = now;
        end
    endfunction

    task automatic advance_levels(input t_in_item t, output t_out_item r);
        logic               ovr_empty;
        logic [PeriodW-1:0] period;
        logic [ScaledW-1:0] d;
        ovr_empty = ~t.overrun_present;
        if (t.start_ok) begin
            if (t.pipet_present) pip_out = 1'b0;
            if (t.cap_present) cap_out = 1'b0;
            if (t.second_home && t.third_home && t.pipet_present && t.cap_present) begin
                if (!run) fault = 1'b0;
                run = 1'b1;
                stop_l = 1'b0;
            end
        end
        if (run) begin
            if (t.stop_button || fault || ovr_empty || pip_out || cap_out) stop_l = 1'b1;
            cnt_lvl = t.exit_sensor;
            if (t.exit_sensor) ej_seen = 1'b1;
            if (angle_deg() == DEG_EJECT_CHECK && !ej_seen) fault = 1'b1;

            if (t.home_sensor && !slow) begin
                pip_out = ~t.pipet_present;
                cap_out = ~t.cap_present;
                pos = '0;
                ej_seen = 1'b0;
                if (stop_l) begin
                    slow = 1'b1;
                    run = 1'b0;
                    ram = 1'b0;
                end
            end

            if (slow && scaled_pos() < SLOW_LIMIT_1) begin
                period = SLOW_PERIOD_1;
            end else if (slow && scaled_pos() < SLOW_LIMIT_2) begin
                period = SLOW_PERIOD_2;
            end else if (slow && scaled_pos() < SLOW_LIMIT_3) begin
                period = SLOW_PERIOD_3;
            end else begin
                slow = 1'b0;
                period = cruise_p;
            end

            if (toggle_axis(0, t.time_us, period) && pos != POS_MAX) pos = pos + 1'b1;

            if (!slow) begin
                if (t.second_home) home2 = 1'b1;
                if (t.second_away) home2 = 1'b0;
                d = angle_deg();
                if (d == DEG_RAM_ON && !ovr_empty) ram = 1'b1;
                if (d == DEG_AIR_ON) begin
                    ram = 1'b0;
                    air = 1'b1;
                end
                if (d == DEG_AIR_OFF) air = 1'b0;
                if ((d < DEG_SECOND_TURN && home2) || (d > DEG_SECOND_TURN && !home2))
                    void'(toggle_axis(1, t.time_us, second_p));
                if (t.third_home) home3 = 1'b1;
                if (t.third_away) home3 = 1'b0;
                if ((d > DEG_THIRD_START && d < DEG_THIRD_TURN && home3)
                        || (d > DEG_THIRD_TURN && !home3))
                    void'(toggle_axis(2, t.time_us, third_p));
            end
        end

        r.main_step   = phase[0];
        r.second_step = phase[1];
        r.third_step  = phase[2];
        r.ram_on      = ram;
        r.air_on      = air;
        r.count_pulse = cnt_lvl;
        r.running     = run;
        r.ramping     = slow;
        r.eject_fault = fault;
        r.feed_empty  = pip_out | cap_out | ovr_empty;
    endtask

    task automatic note_failure(input string msg);
        errors++;
        if (reported < ReportLimit) begin
            $display("%s", msg);
            reported++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item due;
        t_out_item fresh;
        if (!i_rst_n) begin
            cruise_p = CRUISE_PERIOD_RST;
            second_p = SECOND_PERIOD_RST;
            third_p  = THIRD_PERIOD_RST;
            dps      = DEG_PER_STEP_RST;
            run = 1'b0; slow = 1'b1; stop_l = 1'b0; fault = 1'b0;
            ej_seen = 1'b0; pip_out = 1'b0; cap_out = 1'b0;
            pos = '0; phase = '0;
            last_t[0] = '0; last_t[1] = '0; last_t[2] = '0;
            ram = 1'b0; air = 1'b0; home2 = 1'b1; home3 = 1'b1; cnt_lvl = 1'b0;
            levels_due.delete();
            errors = 0;
            reported = 0;
            results = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                results++;
                if (levels_due.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with no tick pending: %b",
                                           results, i_out_data));
                end else begin
                    due = levels_due.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        if (i_out_data[i] !== due[i])
                            note_failure($sformatf("result %0d: %s expected %b got %b",
                                                   results, level_names[i], due[i],
                                                   i_out_data[i]));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.reg_index)
                    REG_CRUISE_PERIOD: cruise_p = i_cfg_data.wdata;
                    REG_SECOND_PERIOD: second_p = i_cfg_data.wdata;
                    REG_THIRD_PERIOD:  third_p  = i_cfg_data.wdata;
                    REG_DEG_PER_STEP:  dps      = i_cfg_data.wdata[DpsW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_levels(i_in_data, fresh);
                levels_due.push_back(fresh);
            end
        end
        o_errors  <= errors;
        o_pending <= levels_due.size();
        o_results <= results;
    end

endmodule

@@ test/rotary_cycle_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module rotary_cycle_sequencer_core_tb;
    import rcs_pkg::*;

    localparam logic [10:0] TICK_START = 11'h400;
    localparam logic [10:0] TICK_STOP  = 11'h200;
    localparam logic [10:0] TICK_HOME  = 11'h100;
    localparam logic [10:0] TICK_EXIT  = 11'h080;
    localparam logic [10:0] TICK_PIPET = 11'h040;
    localparam logic [10:0] TICK_CAP   = 11'h020;
    localparam logic [10:0] TICK_OVR   = 11'h010;
    localparam logic [10:0] TICK_S2H   = 11'h008;
    localparam logic [10:0] TICK_S2A   = 11'h004;
    localparam logic [10:0] TICK_S3H   = 11'h002;
    localparam logic [10:0] TICK_S3A   = 11'h001;
    localparam logic [10:0] TICK_FEEDS = TICK_PIPET | TICK_CAP | TICK_OVR;
    localparam logic [10:0] TICK_PRECHECK = TICK_PIPET | TICK_CAP | TICK_S2H | TICK_S3H;

    localparam int StallCycles = 300;
    localparam int SweepTicks  = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rcs_stream_if #(.t_payload(t_cfg_write)) cfg_if ();
    rcs_stream_if #(.t_payload(t_in_item))   tick_if ();
    rcs_stream_if #(.t_payload(t_out_item))  level_if ();

    int fail_count, pending, result_count;
    int tick_idle_pct = 35;
    int level_idle_pct = 35;
    logic hold_req = 1'b0;
    int hold_left = 0;

    logic [31:0] now_us;
    int ticks_sent = 0;
    int settings_done = 0;
    int since_home = 0;
    int home_gap = 300;
    logic restart_due = 1'b0;
    int phase_len [7] = '{250, 450, 120, 400, 350, 150, 200};

    always #2 i_clk = ~i_clk;

    rotary_cycle_sequencer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (tick_if),
        .o_out   (level_if)
    );

    rcs_level_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_if.valid),
        .i_cfg_ready (cfg_if.ready),
        .i_cfg_data  (cfg_if.data),
        .i_in_valid  (tick_if.valid),
        .i_in_ready  (tick_if.ready),
        .i_in_data   (tick_if.data),
        .i_out_valid (level_if.valid),
        .i_out_ready (level_if.ready),
        .i_out_data  (level_if.data),
        .o_errors    (fail_count),
        .o_pending   (pending),
        .o_results   (result_count)
    );

    // Result side: random back-pressure, plus one long stall on request.
    initial begin
        level_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = StallCycles;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                level_if.ready <= 1'b0;
                hold_left--;
            end else begin
                level_if.ready <= ($urandom_range(99) >= level_idle_pct);
            end
        end
    end

    task automatic send_tick(input logic [31:0] t, input logic [10:0] flags);
        while ($urandom_range(99) < tick_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.data  <= t_in_item'({t, flags});
        do @(posedge i_clk); while (!(tick_if.valid && tick_if.ready));
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= t_cfg_write'{reg_index: idx, wdata: val};
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
    endtask

    // Registers change only once every tick has produced its result.
    task automatic configure(input logic [PeriodW-1:0] cruise, input logic [PeriodW-1:0] second,
                             input logic [PeriodW-1:0] third, input logic [DpsW-1:0] dps);
        tick_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(REG_CRUISE_PERIOD, cruise);
        write_reg(REG_SECOND_PERIOD, second);
        write_reg(REG_THIRD_PERIOD, third);
        write_reg(REG_DEG_PER_STEP, CfgDataW'(dps));
        cfg_if.valid <= 1'b0;
        settings_done++;
    endtask

    // Mostly production-like ticks: feeds loaded, home once per revolution, restarts after
    // a stop at home, and timestamps that let the main axis step on most ticks.
    task automatic random_tick(input logic noisy);
        logic [10:0] flags;
        logic [31:0] delta;
        int          pick;
        if (noisy) begin
            flags = 11'($urandom);
            delta = $urandom;
        end else begin
            flags = TICK_FEEDS;
            if ($urandom_range(99) < 5) flags &= ~TICK_PIPET;
            if ($urandom_range(99) < 5) flags &= ~TICK_CAP;
            if ($urandom_range(999) < 5) flags &= ~TICK_OVR;
            if ($urandom_range(99) < 20) flags |= TICK_S2H;
            if ($urandom_range(99) < 20) flags |= TICK_S2A;
            if ($urandom_range(99) < 20) flags |= TICK_S3H;
            if ($urandom_range(99) < 20) flags |= TICK_S3A;
            if ($urandom_range(999) < 5) flags |= TICK_EXIT;
            if ($urandom_range(999) < 3) flags |= TICK_STOP;
            if ($urandom_range(99) < (restart_due ? 70 : 1)) flags |= TICK_START | TICK_PRECHECK;
            restart_due = 1'b0;
            since_home++;
            if (since_home >= home_gap || $urandom_range(999) < 2) begin
                flags |= TICK_HOME;
                since_home = 0;
                home_gap = $urandom_range(450, 150);
                restart_due = 1'b1;
            end
            if ($urandom_range(99) < 3) flags = 11'($urandom) & ~TICK_HOME;
            pick = $urandom_range(99);
            if (pick < 80) delta = $urandom_range(3400, 3001);
            else if (pick < 95) delta = $urandom_range(3000, 0);
            else delta = $urandom;
        end
        now_us += delta;
        send_tick(now_us, flags);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        tick_if.valid <= 1'b0;
        tick_if.data  <= '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks under the reset configuration.
        send_tick(32'd0, 11'h000);
        send_tick(32'd10, TICK_OVR);
        // Start without the slave axes at home only clears the pipet latch.
        send_tick(32'd20, TICK_START | TICK_PIPET | TICK_OVR);
        send_tick(32'd3100, TICK_START | TICK_PRECHECK | TICK_OVR);
        send_tick(32'd3100, TICK_FEEDS);
        send_tick(32'd6100, TICK_FEEDS);
        send_tick(32'd6101, TICK_FEEDS);
        // Home is ignored during slow start.
        send_tick(32'd9200, TICK_HOME | TICK_FEEDS);
        send_tick(32'd12300, TICK_EXIT | TICK_FEEDS);
        send_tick(32'd15400, TICK_STOP | TICK_FEEDS);
        // Start while running clears only the stop latch.
        send_tick(32'd18500, TICK_START | TICK_PRECHECK | TICK_OVR);
        send_tick(32'hFFFF_FF00, TICK_FEEDS);
        // The timestamp wraps here.
        send_tick(32'h0000_0C00, TICK_FEEDS);
        send_tick(32'hFFFF_FFFF, 11'h7FF);
        send_tick(32'd0, 11'h000);
        send_tick(32'd3500, TICK_START | TICK_PIPET | TICK_S2H | TICK_S3H | TICK_OVR);
        send_tick(32'd7000, TICK_S2A | TICK_S3A | TICK_FEEDS);
        now_us = 32'd7000;

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: configure(16'd1000, 16'd380, 16'd520, 8'd90);
                1: configure(16'd1, 16'd1, 16'd1, 8'd180);
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1);
                3: configure(16'd400, 16'd250, 16'd300, 8'd180);
                4: configure(16'($urandom_range(3000, 1)), 16'($urandom_range(2000, 1)),
                             16'($urandom_range(2000, 1)), 8'($urandom_range(180, 100)));
                default: configure(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                                   16'($urandom_range(65535, 1)), 8'($urandom_range(180, 1)));
            endcase
            tick_idle_pct  = (p == 3) ? 0 : 35;
            level_idle_pct = (p == 3) ? 0 : 35;
            since_home = 0;
            restart_due = 1'b1;
            for (int n = 0; n < phase_len[p]; n++) begin
                if (p == 1 && n == 200) hold_req = 1'b1;
                random_tick(p == 5);
            end
        end

        // A short gapless run past the end of slow start, ending in a home pass.
        configure(16'd1, 16'd380, 16'd520, 8'd180);
        tick_idle_pct  = 0;
        level_idle_pct = 0;
        now_us += 32'd3001;
        send_tick(now_us, TICK_START | TICK_PRECHECK | TICK_OVR);
        repeat (SweepTicks) begin
            now_us += 32'd3001;
            send_tick(now_us, TICK_FEEDS);
        end
        now_us += 32'd3001;
        send_tick(now_us, TICK_HOME | TICK_FEEDS);
        tick_idle_pct  = 35;
        level_idle_pct = 35;

        tick_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        $display("Sent %0d ticks over %0d register settings, with a long result stall,",
                 ticks_sent, settings_done);
        $display("a noise phase and a gapless run; %0d results, %0d failures.",
                 result_count, fail_count);
        if (fail_count == 0) begin
            $display("rotary_cycle_sequencer_core_tb: PASS");
        end else begin
            $display("rotary_cycle_sequencer_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("rotary_cycle_sequencer_core_tb: FAIL");
        $finish;
    end

endmodule
